@@ src/wptp_pkg.sv @@
// shared types and constants of the weighted priority task picker
package wptp_pkg;

  localparam int unsigned MAX_ENTRIES = 32;

  localparam logic [7:0] WEIGHT_INIT = 8'd100;
  localparam logic [7:0] CUT_BASE    = 8'd9;
  // floor(4*p/50) == (p*82) >> 10 for every 8-bit p
  localparam logic [6:0] PRIO_RECIP  = 7'd82;
  localparam int unsigned RECIP_SHIFT = 10;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PICK   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_WR,
    S_RM_SCAN,
    S_RM_SHIFT,
    S_PK_SCAN,
    S_PK_CALC,
    S_PK_UPD
  } state_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_LAST,
    RD_SCAN
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ADD,
    WR_SHIFT,
    WR_UPD
  } wr_sel_e;

  typedef enum logic [1:0] {
    ID_ZERO,
    ID_NEW,
    ID_WIN
  } id_sel_e;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [7:0]  weight;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    clr;
    rd_sel_e rd;
    wr_sel_e wr;
    logic    cnt_dec;
    logic    track;
    logic    calc;
    logic    fin;
    status_e status;
    id_sel_e id_sel;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
    logic match;
  } stat_t;

endpackage

@@ src/weighted_priority_task_picker_top.sv @@
// top level of the weighted priority task picker
//
// A request word (req_type_i, priority_req_i, target_id_i) is taken at a
// rising edge where start is high and busy is low. Each request gives
// exactly one result word on result_id_o and status_o, shown for a single
// cycle with done_o high; the receiver cannot stall it.
// A full table answers an add, and an empty one a remove or pick, without
// a scan, as does an unused code. Otherwise an add reads the last entry
// and writes the new one behind it, a remove scans the entry memory one
// entry per cycle and shifts the later entries down, and a pick scans it
// once to find the heaviest weight and once more to rewrite the weights.
// busy falls as the result is issued, so the next request may be accepted
// in the cycle that shows done_o.
// Reset empties the table at once; entry contents need no clearing.
module weighted_priority_task_picker_top #(
  parameter int unsigned MaxEntries = wptp_pkg::MAX_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  priority_req_i,
  input  logic [15:0] target_id_i,
  output logic        done_o,
  output logic [15:0] result_id_o,
  output logic [1:0]  status_o
);

  wptp_pkg::cmd_t  cmd;
  wptp_pkg::stat_t stat;

  wptp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wptp_dp #(
    .MaxEntries (MaxEntries)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .priority_req_i (priority_req_i),
    .target_id_i    (target_id_i),
    .done_o         (done_o),
    .result_id_o    (result_id_o),
    .status_o       (status_o)
  );

endmodule

@@ src/wptp_ctrl.sv @@
// controller state machine of the task picker
module wptp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type_i,
  input  wptp_pkg::stat_t  stat_i,
  output wptp_pkg::cmd_t   cmd_o
);

  wptp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wptp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != wptp_pkg::S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.rd       = wptp_pkg::RD_NONE;
    cmd_o.wr       = wptp_pkg::WR_NONE;
    cmd_o.status   = wptp_pkg::ST_OK;
    cmd_o.id_sel   = wptp_pkg::ID_ZERO;
    case (state_q)
      wptp_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cmd_o.clr  = 1'b1;
          case (wptp_pkg::req_e'(req_type_i))
            wptp_pkg::REQ_ADD: begin
              if (stat_i.full) begin
                cmd_o.fin    = 1'b1;
                cmd_o.status = wptp_pkg::ST_FULL;
              end else begin
                cmd_o.rd = wptp_pkg::RD_LAST;
                state_d  = wptp_pkg::S_ADD_WR;
              end
            end
            wptp_pkg::REQ_REMOVE: begin
              if (stat_i.empty) begin
                cmd_o.fin    = 1'b1;
                cmd_o.status = wptp_pkg::ST_NOT_FOUND;
              end else begin
                state_d = wptp_pkg::S_RM_SCAN;
              end
            end
            wptp_pkg::REQ_PICK: begin
              if (stat_i.empty) begin
                cmd_o.fin    = 1'b1;
                cmd_o.status = wptp_pkg::ST_EMPTY;
              end else begin
                state_d = wptp_pkg::S_PK_SCAN;
              end
            end
            default: begin
              cmd_o.fin = 1'b1;
            end
          endcase
        end
      end
      wptp_pkg::S_ADD_WR: begin
        cmd_o.wr     = wptp_pkg::WR_ADD;
        cmd_o.fin    = 1'b1;
        cmd_o.id_sel = wptp_pkg::ID_NEW;
        state_d      = wptp_pkg::S_IDLE;
      end
      wptp_pkg::S_RM_SCAN: begin
        cmd_o.rd = wptp_pkg::RD_SCAN;
        if (stat_i.match) begin
          if (stat_i.last) begin
            cmd_o.cnt_dec = 1'b1;
            cmd_o.fin     = 1'b1;
            state_d       = wptp_pkg::S_IDLE;
          end else begin
            state_d = wptp_pkg::S_RM_SHIFT;
          end
        end else if (stat_i.last) begin
          cmd_o.fin    = 1'b1;
          cmd_o.status = wptp_pkg::ST_NOT_FOUND;
          state_d      = wptp_pkg::S_IDLE;
        end
      end
      wptp_pkg::S_RM_SHIFT: begin
        cmd_o.rd = wptp_pkg::RD_SCAN;
        cmd_o.wr = wptp_pkg::WR_SHIFT;
        if (stat_i.last) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.fin     = 1'b1;
          state_d       = wptp_pkg::S_IDLE;
        end
      end
      wptp_pkg::S_PK_SCAN: begin
        cmd_o.rd    = wptp_pkg::RD_SCAN;
        cmd_o.track = 1'b1;
        if (stat_i.last) begin
          state_d = wptp_pkg::S_PK_CALC;
        end
      end
      wptp_pkg::S_PK_CALC: begin
        cmd_o.calc = 1'b1;
        cmd_o.clr  = 1'b1;
        state_d    = wptp_pkg::S_PK_UPD;
      end
      wptp_pkg::S_PK_UPD: begin
        cmd_o.rd = wptp_pkg::RD_SCAN;
        cmd_o.wr = wptp_pkg::WR_UPD;
        if (stat_i.last) begin
          cmd_o.fin    = 1'b1;
          cmd_o.id_sel = wptp_pkg::ID_WIN;
          state_d      = wptp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wptp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ src/wptp_dp.sv @@
// datapath of the task picker: entry memory, scan counter and weight arithmetic
module wptp_dp #(
  parameter int unsigned MaxEntries = wptp_pkg::MAX_ENTRIES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wptp_pkg::cmd_t  cmd_i,
  output wptp_pkg::stat_t stat_o,
  input  logic [7:0]      priority_req_i,
  input  logic [15:0]     target_id_i,
  output logic            done_o,
  output logic [15:0]     result_id_o,
  output logic [1:0]      status_o
);

  localparam int unsigned CW = $clog2(MaxEntries + 1);
  localparam int unsigned AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  wptp_pkg::entry_t mem_q [MaxEntries];
  wptp_pkg::entry_t rdata_q;
  wptp_pkg::entry_t wr_data;

  logic [CW-1:0] count_q, cnt_q, ridx_q, win_q;
  logic [CW-1:0] last_idx, rd_addr, wr_addr;
  logic          rvld_q, rd_en, wr_en, done_q;
  logic [7:0]    prio_q, best_q, win_prio_q, j_q, delta_q;
  logic [15:0]   tid_q, win_id_q, new_id, res_id_q;
  logic [1:0]    res_status_q;
  logic [14:0]   prod;
  logic [7:0]    cut, j_d, inc;

  assign last_idx = count_q - CW'(1);
  assign new_id   = (count_q == '0) ? 16'd0 : rdata_q.id + 16'd1;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CW'(MaxEntries));
  assign stat_o.last  = rvld_q && (ridx_q == last_idx);
  assign stat_o.match = rvld_q && (rdata_q.id == tid_q);

  // priority cut of the winner and weight shift of every entry
  assign prod = 15'(win_prio_q) * 15'(wptp_pkg::PRIO_RECIP);
  assign cut  = wptp_pkg::CUT_BASE - 8'(prod[14:wptp_pkg::RECIP_SHIFT]);
  assign j_d  = wptp_pkg::WEIGHT_INIT - best_q;
  assign inc  = (ridx_q == win_q) ? delta_q : j_q;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_q;
    case (cmd_i.rd)
      wptp_pkg::RD_SCAN: begin
        rd_en = (cnt_q < count_q);
      end
      wptp_pkg::RD_LAST: begin
        rd_en   = (count_q != '0);
        rd_addr = last_idx;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ridx_q;
    wr_data = rdata_q;
    case (cmd_i.wr)
      wptp_pkg::WR_ADD: begin
        wr_en   = 1'b1;
        wr_addr = count_q;
        wr_data = '{id: new_id, prio: prio_q, weight: wptp_pkg::WEIGHT_INIT};
      end
      wptp_pkg::WR_SHIFT: begin
        wr_en   = rvld_q;
        wr_addr = ridx_q - CW'(1);
      end
      wptp_pkg::WR_UPD: begin
        wr_en          = rvld_q;
        wr_data.weight = rdata_q.weight + inc;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cnt_q   <= '0;
      rvld_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      rvld_q <= rd_en;
      done_q <= cmd_i.fin;
      if (cmd_i.clr) begin
        cnt_q <= '0;
      end else if (cmd_i.rd == wptp_pkg::RD_SCAN && rd_en) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.wr == wptp_pkg::WR_ADD) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= rd_addr;
    if (cmd_i.load) begin
      prio_q <= priority_req_i;
      tid_q  <= target_id_i;
    end
    if (cmd_i.track && rvld_q && (ridx_q == '0 || rdata_q.weight > best_q)) begin
      best_q     <= rdata_q.weight;
      win_q      <= ridx_q;
      win_id_q   <= rdata_q.id;
      win_prio_q <= rdata_q.prio;
    end
    if (cmd_i.calc) begin
      j_q     <= j_d;
      delta_q <= j_d - cut;
    end
    if (cmd_i.fin) begin
      res_status_q <= cmd_i.status;
      case (cmd_i.id_sel)
        wptp_pkg::ID_NEW: res_id_q <= new_id;
        wptp_pkg::ID_WIN: res_id_q <= win_id_q;
        default:          res_id_q <= 16'd0;
      endcase
    end
  end

  assign done_o      = done_q;
  assign result_id_o = res_id_q;
  assign status_o    = res_status_q;

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench of the weighted priority task picker
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned ITEMS_PER_PHASE = 300;
  localparam int unsigned BIAS_SPAN = 64;

  typedef struct packed {
    logic [15:0]       id;
    wptp_pkg::status_e status;
  } outcome_t;

  class task_table_model;
    logic [15:0] ids [wptp_pkg::MAX_ENTRIES];
    logic [7:0]  prios [wptp_pkg::MAX_ENTRIES];
    logic [7:0]  weights [wptp_pkg::MAX_ENTRIES];
    int unsigned count;
    int unsigned failures;
    outcome_t    due_outcomes [$];

    function new();
      count = 0;
      failures = 0;
    endfunction

    function logic [15:0] any_id();
      if (count == 0) begin
        return 16'($urandom_range(0, 65535));
      end
      return ids[$urandom_range(0, count - 1)];
    endfunction

    function void note_request(logic [1:0] req, logic [7:0] prio, logic [15:0] tid);
      outcome_t    res;
      int unsigned pos;
      int unsigned win;
      int unsigned k;
      logic [7:0]  jump;
      logic [7:0]  cut;
      res.id = '0;
      res.status = wptp_pkg::ST_OK;
      case (req)
        wptp_pkg::REQ_ADD: begin
          if (count >= wptp_pkg::MAX_ENTRIES) begin
            res.status = wptp_pkg::ST_FULL;
          end else begin
            res.id = (count == 0) ? 16'd0 : ids[count - 1] + 16'd1;
            ids[count] = res.id;
            prios[count] = prio;
            weights[count] = wptp_pkg::WEIGHT_INIT;
            count++;
          end
        end
        wptp_pkg::REQ_REMOVE: begin
          pos = 0;
          while (pos < count && ids[pos] != tid) pos++;
          if (pos == count) begin
            res.status = wptp_pkg::ST_NOT_FOUND;
          end else begin
            for (k = pos; k + 1 < count; k++) begin
              ids[k] = ids[k + 1];
              prios[k] = prios[k + 1];
              weights[k] = weights[k + 1];
            end
            count--;
          end
        end
        wptp_pkg::REQ_PICK: begin
          if (count == 0) begin
            res.status = wptp_pkg::ST_EMPTY;
          end else begin
            win = 0;
            for (k = 1; k < count; k++) begin
              if (weights[k] > weights[win]) win = k;
            end
            jump = 8'd100 - weights[win];
            cut = wptp_pkg::CUT_BASE - 8'((4 * int'(prios[win])) / 50);
            weights[win] = weights[win] - cut;
            for (k = 0; k < count; k++) begin
              weights[k] = weights[k] + jump;
            end
            res.id = ids[win];
          end
        end
        default: ;
      endcase
      due_outcomes.push_back(res);
    endfunction

    function void check_outcome(logic [15:0] id, logic [1:0] st);
      outcome_t want;
      if (due_outcomes.size() == 0) begin
        $error("result word with none outstanding: result_id %0d status %0d", id, st);
        failures++;
        return;
      end
      want = due_outcomes.pop_front();
      if (id !== want.id) begin
        $error("result_id: expected %0d, actual %0d", want.id, id);
        failures++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = wptp_pkg::REQ_ADD;
  logic [7:0]  priority_req_i = '0;
  logic [15:0] target_id_i = '0;
  logic        done_o;
  logic [15:0] result_id_o;
  logic [1:0]  status_o;

  task_table_model model = new();
  int unsigned send_idle_pct = 37;

  weighted_priority_task_picker_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .priority_req_i (priority_req_i),
    .target_id_i    (target_id_i),
    .done_o         (done_o),
    .result_id_o    (result_id_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (done_o === 1'b1) model.check_outcome(result_id_o, status_o);
  end

  task automatic issue_request(input logic [1:0] req, input logic [7:0] prio,
                               input logic [15:0] tid);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= req;
    priority_req_i <= prio;
    target_id_i <= tid;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    model.note_request(req, prio, tid);
  endtask

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned roll;
    int unsigned phase;
    int unsigned n;
    logic [1:0]  op;
    logic [15:0] tid;
    bit          filling;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, unused code, priority extremes and cut steps
    issue_request(wptp_pkg::REQ_PICK, 8'hFF, 16'hFFFF);
    issue_request(wptp_pkg::REQ_REMOVE, 8'h00, 16'hFFFF);
    issue_request(REQ_UNUSED, 8'hFF, 16'hFFFF);
    issue_request(wptp_pkg::REQ_ADD, 8'h00, 16'h0000);
    issue_request(wptp_pkg::REQ_ADD, 8'hFF, 16'hFFFF);
    issue_request(wptp_pkg::REQ_ADD, 8'd12, 16'h0000);
    issue_request(wptp_pkg::REQ_ADD, 8'd13, 16'h0000);
    repeat (4) issue_request(wptp_pkg::REQ_PICK, 8'h00, 16'h0000);
    issue_request(wptp_pkg::REQ_REMOVE, 8'h00, 16'd1);
    issue_request(wptp_pkg::REQ_REMOVE, 8'h00, 16'd1);
    issue_request(wptp_pkg::REQ_REMOVE, 8'h00, 16'd3);
    issue_request(wptp_pkg::REQ_REMOVE, 8'h00, 16'd0);
    issue_request(wptp_pkg::REQ_PICK, 8'h00, 16'h0000);
    issue_request(wptp_pkg::REQ_ADD, 8'd200, 16'h0000);
    issue_request(wptp_pkg::REQ_PICK, 8'h00, 16'h0000);
    issue_request(REQ_UNUSED, 8'h00, 16'h0000);
    issue_request(wptp_pkg::REQ_PICK, 8'h00, 16'h0000);

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 87 : 0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        filling = ((n / BIAS_SPAN) % 2) == 0;
        roll = $urandom_range(0, 99);
        if (filling) begin
          op = (roll < 55) ? wptp_pkg::REQ_ADD : (roll < 70) ? wptp_pkg::REQ_REMOVE :
               (roll < 95) ? wptp_pkg::REQ_PICK : REQ_UNUSED;
        end else begin
          op = (roll < 15) ? wptp_pkg::REQ_ADD : (roll < 65) ? wptp_pkg::REQ_REMOVE :
               (roll < 95) ? wptp_pkg::REQ_PICK : REQ_UNUSED;
        end
        if (op == wptp_pkg::REQ_REMOVE && model.count != 0 && $urandom_range(0, 3) != 0) begin
          tid = model.any_id();
        end else begin
          tid = 16'($urandom_range(0, 65535));
        end
        issue_request(op, 8'($urandom_range(0, 255)), tid);
      end
    end

    // drain the table, then refill from id zero
    while (model.count != 0) begin
      issue_request(wptp_pkg::REQ_REMOVE, 8'($urandom_range(0, 255)), model.ids[0]);
    end
    issue_request(wptp_pkg::REQ_ADD, 8'($urandom_range(0, 255)), 16'h0000);
    issue_request(wptp_pkg::REQ_ADD, 8'($urandom_range(0, 255)), 16'h0000);
    issue_request(wptp_pkg::REQ_PICK, 8'h00, 16'h0000);
    issue_request(wptp_pkg::REQ_REMOVE, 8'h00, model.ids[1]);
    issue_request(wptp_pkg::REQ_PICK, 8'h00, 16'h0000);
    start <= 1'b0;

    while (model.due_outcomes.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (model.failures == 0 && model.due_outcomes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
